[src/plti_pkg.sv]
// shared types, constants and the arctangent table for the linkage solver
package plti_pkg;

   localparam int ANG_W = 16;
   localparam int CFG_W = 20;
   localparam int SQ_DIGITS = 31;

   localparam logic [1:0] REG_LINK_OFFSET      = 2'd0;
   localparam logic [1:0] REG_CRANK_LENGTH     = 2'd1;
   localparam logic [1:0] REG_LEFT_ROD_HEIGHT  = 2'd2;
   localparam logic [1:0] REG_RIGHT_ROD_HEIGHT = 2'd3;

   localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      logic               flip;
   } rot_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
   } vec_type;

   typedef struct packed {
      logic [61:0] rad;
      logic [32:0] rem;
      logic [30:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [17:0] cx;
      logic signed [17:0] cy;
      logic signed [17:0] sy;
      logic signed [17:0] sxsy;
      logic signed [17:0] sxcy;
   } trig_type;

   typedef struct packed {
      logic [39:0] ll;
      logic [39:0] ld;
      logic [39:0] dd;
      logic [54:0] k0;
   } cfgp_type;

   function automatic logic [29:0] atan_q30(input int unsigned i);
      logic [29:0] v;
      case (i)
         0: v = 30'h3243F6A8;
         1: v = 30'h1DAC6705;
         2: v = 30'h0FADBAFC;
         3: v = 30'h07F56EA6;
         4: v = 30'h03FEAB76;
         5: v = 30'h01FFD55B;
         6: v = 30'h00FFFAAA;
         7: v = 30'h007FFF55;
         8: v = 30'h003FFFEA;
         9: v = 30'h001FFFFD;
         10: v = 30'h000FFFFF;
         11: v = 30'h0007FFFF;
         12: v = 30'h0003FFFF;
         13: v = 30'h0001FFFF;
         14: v = 30'h0000FFFF;
         15: v = 30'h00007FFF;
         16: v = 30'h00003FFF;
         17: v = 30'h00001FFF;
         18: v = 30'h00000FFF;
         19: v = 30'h000007FF;
         20: v = 30'h000003FF;
         21: v = 30'h000001FF;
         22: v = 30'h000000FF;
         23: v = 30'h0000007F;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage

[src/plti_rot_cell.sv]
// one rotation-mode cordic cell for sine and cosine
module plti_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              en,
   input  plti_pkg::rot_type d_in,
   output plti_pkg::rot_type d_out
);

   localparam logic signed [35:0] ATAN = $signed({6'b0, plti_pkg::atan_q30(STAGE)});

   plti_pkg::rot_type q_ff;
   plti_pkg::rot_type q_in;

   always_comb begin
      q_in = d_in;
      if (d_in.z >= 0) begin
         q_in.x = d_in.x - (d_in.y >>> STAGE);
         q_in.y = d_in.y + (d_in.x >>> STAGE);
         q_in.z = d_in.z - ATAN;
      end else begin
         q_in.x = d_in.x + (d_in.y >>> STAGE);
         q_in.y = d_in.y - (d_in.x >>> STAGE);
         q_in.z = d_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

[src/plti_vec_cell.sv]
// one vectoring-mode cordic cell for arctangent
module plti_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              en,
   input  plti_pkg::vec_type d_in,
   output plti_pkg::vec_type d_out
);

   localparam logic signed [32:0] ATAN = $signed({3'b0, plti_pkg::atan_q30(STAGE)});

   plti_pkg::vec_type q_ff;
   plti_pkg::vec_type q_in;

   always_comb begin
      if (d_in.y >= 0) begin
         q_in.x = d_in.x + (d_in.y >>> STAGE);
         q_in.y = d_in.y - (d_in.x >>> STAGE);
         q_in.z = d_in.z + ATAN;
      end else begin
         q_in.x = d_in.x - (d_in.y >>> STAGE);
         q_in.y = d_in.y + (d_in.x >>> STAGE);
         q_in.z = d_in.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

[src/plti_sqrt_cell.sv]
// one digit of the integer square root, two radicand bits per cell
module plti_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  plti_pkg::sqrt_type d_in,
   output plti_pkg::sqrt_type d_out
);

   plti_pkg::sqrt_type q_ff;
   plti_pkg::sqrt_type q_in;
   logic [35:0]        trial;

   always_comb begin
      trial = {1'b0, d_in.rem, d_in.rad[61:60]} - {3'b0, d_in.root, 2'b01};
      q_in.rad = {d_in.rad[59:0], 2'b00};
      if (!trial[35]) begin
         q_in.rem  = trial[32:0];
         q_in.root = {d_in.root[29:0], 1'b1};
      end else begin
         q_in.rem  = {d_in.rem[30:0], d_in.rad[61:60]};
         q_in.root = {d_in.root[29:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

[src/plti_side.sv]
// one actuator side: coefficients, scaling, reach test, root and arctangent chains
module plti_side #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                clock,
   input  logic                en,
   input  plti_pkg::trig_type  trig,
   input  plti_pkg::cfgp_type  cfgp,
   input  logic [39:0]         lh,
   input  logic [39:0]         dh,
   output logic signed [33:0]  ang,
   output logic                reach
);

   localparam int NP = 7;
   localparam int P_LLCY = 0;
   localparam int P_LDSXSY = 1;
   localparam int P_LLSY = 2;
   localparam int P_LDSXCY = 3;
   localparam int P_DDCX = 4;
   localparam int P_LHSY = 5;
   localparam int P_DHSXCY = 6;
   localparam int SQ = plti_pkg::SQ_DIGITS;
   localparam int AUXD = SQ + 3;
   localparam int RCHD = SQ + CORDIC_STAGES;

   typedef struct packed {
      logic        sa;
      logic [29:0] ma;
      logic [29:0] mb;
      logic        sc;
      logic [29:0] mc;
   } aux_type;

   logic [39:0]        opu [NP];
   logic signed [17:0] opt [NP];
   logic signed [38:0] pp_lo_ff [NP];
   logic signed [38:0] pp_hi_ff [NP];
   logic signed [59:0] pr_ff [NP];
   logic signed [59:0] a1_ff, bt1_ff, bt2_ff, ct1_ff, ct2_ff;
   logic signed [59:0] ca_ff, cb_ff, cc_ff;
   logic [58:0]        ma_ff, mb_ff, mc_ff, orv_ff;
   logic               sa_ff, sc_ff;
   logic [58:0]        ma2_ff, mb2_ff, mc2_ff;
   logic               sa2_ff, sc2_ff;
   logic [4:0]         shift_ff;
   logic [4:0]         shift_in;
   aux_type            n3_ff;
   logic [59:0]        aa_ff, bb_ff, csq_ff;
   logic [29:0]        mc4_ff;
   logic [60:0]        sum_ff, lim_ff, csq5_ff;
   logic [60:0]        d_ff;
   logic               reach6_ff;
   aux_type            aux_ff [AUXD];
   logic               rch_ff [RCHD];
   plti_pkg::sqrt_type sq_p [SQ+1];
   plti_pkg::vec_type  vc_p [CORDIC_STAGES+1];
   plti_pkg::vec_type  va_p [CORDIC_STAGES+1];
   logic signed [33:0] ang_ff;
   logic               reach_ff;
   aux_type            aux_end;

   always_comb begin
      opu[P_LLCY]   = cfgp.ll;  opt[P_LLCY]   = trig.cy;
      opu[P_LDSXSY] = cfgp.ld;  opt[P_LDSXSY] = trig.sxsy;
      opu[P_LLSY]   = cfgp.ll;  opt[P_LLSY]   = trig.sy;
      opu[P_LDSXCY] = cfgp.ld;  opt[P_LDSXCY] = trig.sxcy;
      opu[P_DDCX]   = cfgp.dd;  opt[P_DDCX]   = trig.cx;
      opu[P_LHSY]   = lh;       opt[P_LHSY]   = trig.sy;
      opu[P_DHSXCY] = dh;       opt[P_DHSXCY] = trig.sxcy;
   end

   // leading one of the magnitudes above bit 29 sets the scale
   always_comb begin
      shift_in = '0;
      for (int k = 30; k < 59; k++) begin
         if (orv_ff[k]) begin
            shift_in = 5'(k - 29);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // 40 by 18 products split in two halves
         for (int p = 0; p < NP; p++) begin
            pp_lo_ff[p] <= $signed({1'b0, opu[p][19:0]}) * opt[p];
            pp_hi_ff[p] <= $signed({1'b0, opu[p][39:20]}) * opt[p];
            pr_ff[p]    <= (60'(pp_hi_ff[p]) <<< 20) + 60'(pp_lo_ff[p]);
         end
         a1_ff  <= pr_ff[P_LDSXSY] - pr_ff[P_LLCY];
         bt1_ff <= $signed({6'b0, lh, 14'b0}) - pr_ff[P_LLSY];
         bt2_ff <= pr_ff[P_LDSXCY];
         ct1_ff <= pr_ff[P_DDCX] - $signed({5'b0, cfgp.k0});
         ct2_ff <= pr_ff[P_LHSY] + pr_ff[P_DHSXCY];
         ca_ff  <= a1_ff;
         cb_ff  <= bt1_ff - bt2_ff;
         cc_ff  <= ct1_ff + ct2_ff;

         ma_ff  <= ca_ff[59] ? 59'(-ca_ff) : ca_ff[58:0];
         mb_ff  <= cb_ff[59] ? 59'(-cb_ff) : cb_ff[58:0];
         mc_ff  <= cc_ff[59] ? 59'(-cc_ff) : cc_ff[58:0];
         orv_ff <= (ca_ff[59] ? 59'(-ca_ff) : ca_ff[58:0])
                 | (cb_ff[59] ? 59'(-cb_ff) : cb_ff[58:0])
                 | (cc_ff[59] ? 59'(-cc_ff) : cc_ff[58:0]);
         sa_ff  <= ca_ff[59];
         sc_ff  <= cc_ff[59];

         shift_ff <= shift_in;
         ma2_ff   <= ma_ff;
         mb2_ff   <= mb_ff;
         mc2_ff   <= mc_ff;
         sa2_ff   <= sa_ff;
         sc2_ff   <= sc_ff;

         n3_ff.ma <= 30'(ma2_ff >> shift_ff);
         n3_ff.mb <= 30'(mb2_ff >> shift_ff);
         n3_ff.mc <= 30'(mc2_ff >> shift_ff);
         n3_ff.sa <= sa2_ff;
         n3_ff.sc <= sc2_ff;

         aa_ff  <= 60'(n3_ff.ma) * 60'(n3_ff.ma);
         bb_ff  <= 60'(n3_ff.mb) * 60'(n3_ff.mb);
         csq_ff <= 60'(n3_ff.mc) * 60'(n3_ff.mc);
         mc4_ff <= n3_ff.mc;

         // floor sqrt(s) <= m exactly when s <= m*m + 2m
         sum_ff  <= 61'(aa_ff) + 61'(bb_ff);
         lim_ff  <= 61'(csq_ff) + {30'b0, mc4_ff, 1'b0};
         csq5_ff <= 61'(csq_ff);

         d_ff      <= sum_ff - csq5_ff;
         reach6_ff <= sum_ff > lim_ff;

         aux_ff[0] <= n3_ff;
         for (int k = 1; k < AUXD; k++) begin
            aux_ff[k] <= aux_ff[k-1];
         end
         rch_ff[0] <= reach6_ff;
         for (int k = 1; k < RCHD; k++) begin
            rch_ff[k] <= rch_ff[k-1];
         end

         ang_ff   <= 34'(vc_p[CORDIC_STAGES].z) - 34'(va_p[CORDIC_STAGES].z);
         reach_ff <= rch_ff[RCHD-1];
      end
   end

   assign sq_p[0].rad  = {1'b0, d_ff};
   assign sq_p[0].rem  = '0;
   assign sq_p[0].root = '0;

   for (genvar g = 0; g < SQ; g++) begin : g_sqrt
      plti_sqrt_cell u_cell (
         .clock (clock),
         .en    (en),
         .d_in  (sq_p[g]),
         .d_out (sq_p[g+1])
      );
   end

   assign aux_end = aux_ff[AUXD-1];

   assign vc_p[0].x = $signed({3'b0, sq_p[SQ].root});
   assign vc_p[0].y = aux_end.sc ? -$signed({4'b0, aux_end.mc}) : $signed({4'b0, aux_end.mc});
   assign vc_p[0].z = '0;
   assign va_p[0].x = $signed({4'b0, aux_end.mb});
   assign va_p[0].y = aux_end.sa ? -$signed({4'b0, aux_end.ma}) : $signed({4'b0, aux_end.ma});
   assign va_p[0].z = '0;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      plti_vec_cell #(.STAGE(g)) u_c (
         .clock (clock),
         .en    (en),
         .d_in  (vc_p[g]),
         .d_out (vc_p[g+1])
      );
      plti_vec_cell #(.STAGE(g)) u_a (
         .clock (clock),
         .en    (en),
         .d_in  (va_p[g]),
         .d_out (va_p[g+1])
      );
   end

   assign ang   = ang_ff;
   assign reach = reach_ff;

endmodule

[src/parallel_link_torso_ik.sv]
// top level of the two-actuator linkage inverse kinematics solver
// usage:
//   req channel: one word per target, tdata holds roll then pitch (Q3.13 rad).
//   rsp channel: one word per target, the two crank angles (Q3.13 rad) and
//   an unreachable flag in tuser; both angles read zero when it is set.
//   csr channel: register writes (offset, crank length, left and right rod
//   heights); always ready, write only while no target is in flight.
// from acceptance to rsp_tvalid a target passes, in order, through:
//   a fold stage, the sine/cosine cordic cells, three trig stages, four
//   coefficient stages, six scale and reach stages, 31 square root digit
//   cells, the arctangent cordic cells, a difference stage and the output
//   register. one target is accepted every cycle while rsp is not stalled.
// every stage moves on the same enable, so a stalled rsp side freezes the
//   whole chain and req_tready drops until the held word is taken.
// reset clears the valid line and the csr registers; config products settle
//   after a write (products, then k0), well before any new target reaches them.
module parallel_link_torso_ik #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // roll_angle [15:0], pitch_angle [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // left_crank_angle [15:0], right_crank_angle [31:16]
   output logic        rsp_tuser,  // unreachable [0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int LAT = 2 * CORDIC_STAGES + 16 + plti_pkg::SQ_DIGITS;

   logic               adv;
   logic [LAT-1:0]     vld_ff;
   logic [19:0]        offset_ff, crank_ff, lheight_ff, rheight_ff;
   logic [39:0]        ll_ff, ld_ff, dd_ff, lh_l_ff, lh_r_ff, dh_l_ff, dh_r_ff;
   logic [54:0]        k0_ff;
   plti_pkg::rot_type  rp_p [CORDIC_STAGES+1];
   plti_pkg::rot_type  rr_p [CORDIC_STAGES+1];
   plti_pkg::rot_type  fold_p_ff, fold_r_ff;
   logic signed [17:0] sx_ff, cx_ff, sy_ff, cy_ff;
   logic signed [35:0] sxsy_p_ff, sxcy_p_ff;
   logic signed [17:0] cx2_ff, cy2_ff, sy2_ff;
   plti_pkg::trig_type trig_l_ff, trig_r_ff;
   plti_pkg::cfgp_type cfgp;
   logic signed [33:0] ang_l, ang_r;
   logic               reach_l, reach_r;
   logic [15:0]        q_l, q_r;
   logic [31:0]        rsp_tdata_ff;
   logic               rsp_tuser_ff;

   function automatic plti_pkg::rot_type fold(input logic signed [15:0] a);
      plti_pkg::rot_type r;
      logic signed [35:0] z;
      z = $signed({{3{a[15]}}, a, 17'b0});
      r.x = plti_pkg::GAIN_Q30;
      r.y = '0;
      r.flip = 1'b0;
      r.z = z;
      if (z > plti_pkg::HALF_PI_Q30) begin
         r.z = z - plti_pkg::PI_Q30;
         r.flip = 1'b1;
      end else if (z < -plti_pkg::HALF_PI_Q30) begin
         r.z = z + plti_pkg::PI_Q30;
         r.flip = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [17:0] rnd_q14(input logic signed [35:0] v, input logic f);
      logic signed [35:0] t;
      t = ((f ? -v : v) + 36'sd32768) >>> 16;
      return t[17:0];
   endfunction

   function automatic logic signed [17:0] rnd_prod(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = (v + 36'sd8192) >>> 14;
      return t[17:0];
   endfunction

   function automatic logic [15:0] to_q13(input logic signed [33:0] v);
      logic signed [33:0] t;
      logic [15:0]        r;
      t = (v + 34'sd65536) >>> 17;
      if (t > 34'sd32767) begin
         r = 16'h7FFF;
      end else if (t < -34'sd32768) begin
         r = 16'h8000;
      end else begin
         r = t[15:0];
      end
      return r;
   endfunction

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         offset_ff  <= '0;
         crank_ff   <= '0;
         lheight_ff <= '0;
         rheight_ff <= '0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
         end
         if (csr_valid) begin
            case (csr_index)
               plti_pkg::REG_LINK_OFFSET:      offset_ff  <= csr_data;
               plti_pkg::REG_CRANK_LENGTH:     crank_ff   <= csr_data;
               plti_pkg::REG_LEFT_ROD_HEIGHT:  lheight_ff <= csr_data;
               plti_pkg::REG_RIGHT_ROD_HEIGHT: rheight_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // products of the dimensions, recomputed every cycle
   always_ff @(posedge clock) begin
      ll_ff   <= 40'(crank_ff) * 40'(crank_ff);
      ld_ff   <= 40'(crank_ff) * 40'(offset_ff);
      dd_ff   <= 40'(offset_ff) * 40'(offset_ff);
      lh_l_ff <= 40'(crank_ff) * 40'(lheight_ff);
      lh_r_ff <= 40'(crank_ff) * 40'(rheight_ff);
      dh_l_ff <= 40'(offset_ff) * 40'(lheight_ff);
      dh_r_ff <= 40'(offset_ff) * 40'(rheight_ff);
      k0_ff   <= {14'b0, 41'(ll_ff) + 41'(dd_ff)} << 14;
   end

   assign cfgp.ll = ll_ff;
   assign cfgp.ld = ld_ff;
   assign cfgp.dd = dd_ff;
   assign cfgp.k0 = k0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fold_p_ff <= fold(req_tdata[31:16]);
         fold_r_ff <= fold(req_tdata[15:0]);

         sx_ff <= rnd_q14(rp_p[CORDIC_STAGES].y, rp_p[CORDIC_STAGES].flip);
         cx_ff <= rnd_q14(rp_p[CORDIC_STAGES].x, rp_p[CORDIC_STAGES].flip);
         sy_ff <= rnd_q14(rr_p[CORDIC_STAGES].y, rr_p[CORDIC_STAGES].flip);
         cy_ff <= rnd_q14(rr_p[CORDIC_STAGES].x, rr_p[CORDIC_STAGES].flip);

         sxsy_p_ff <= sx_ff * sy_ff;
         sxcy_p_ff <= sx_ff * cy_ff;
         cx2_ff    <= cx_ff;
         cy2_ff    <= cy_ff;
         sy2_ff    <= sy_ff;

         // the right side sees the cross terms with the opposite sign
         trig_l_ff.cx   <= cx2_ff;
         trig_l_ff.cy   <= cy2_ff;
         trig_l_ff.sy   <= sy2_ff;
         trig_l_ff.sxsy <= rnd_prod(sxsy_p_ff);
         trig_l_ff.sxcy <= rnd_prod(sxcy_p_ff);
         trig_r_ff.cx   <= cx2_ff;
         trig_r_ff.cy   <= cy2_ff;
         trig_r_ff.sy   <= sy2_ff;
         trig_r_ff.sxsy <= -rnd_prod(sxsy_p_ff);
         trig_r_ff.sxcy <= -rnd_prod(sxcy_p_ff);

         if (reach_l && reach_r) begin
            rsp_tdata_ff <= {q_r, q_l};
            rsp_tuser_ff <= 1'b0;
         end else begin
            rsp_tdata_ff <= '0;
            rsp_tuser_ff <= 1'b1;
         end
      end
   end

   assign rp_p[0] = fold_p_ff;
   assign rr_p[0] = fold_r_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      plti_rot_cell #(.STAGE(g)) u_p (
         .clock (clock),
         .en    (adv),
         .d_in  (rp_p[g]),
         .d_out (rp_p[g+1])
      );
      plti_rot_cell #(.STAGE(g)) u_r (
         .clock (clock),
         .en    (adv),
         .d_in  (rr_p[g]),
         .d_out (rr_p[g+1])
      );
   end

   plti_side #(.CORDIC_STAGES(CORDIC_STAGES)) u_left (
      .clock (clock),
      .en    (adv),
      .trig  (trig_l_ff),
      .cfgp  (cfgp),
      .lh    (lh_l_ff),
      .dh    (dh_l_ff),
      .ang   (ang_l),
      .reach (reach_l)
   );

   plti_side #(.CORDIC_STAGES(CORDIC_STAGES)) u_right (
      .clock (clock),
      .en    (adv),
      .trig  (trig_r_ff),
      .cfgp  (cfgp),
      .lh    (lh_r_ff),
      .dh    (dh_r_ff),
      .ang   (ang_r),
      .reach (reach_r)
   );

   assign q_l = to_q13(ang_l);
   assign q_r = to_q13(ang_r);

`ifndef ASSERT_OFF
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("unreachable result carries nonzero angles");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_crank_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == plti_pkg::REG_CRANK_LENGTH |=> crank_ff == $past(csr_data))
      else $error("crank length write lost");
`endif

endmodule
